FILE: src/dels_pkg.sv
// Shared types and constants of the double-ended list store.
`default_nettype none
package dels_pkg;

	localparam int DEPTH_DEF = 16;

	// operation codes
	localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [1:0] OP_DROP_FRONT = 2'd2;
	localparam logic [1:0] OP_READ_ALL   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] item;
		logic [1:0]         status;
		logic               last;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // request taken this cycle
		logic rd_issue; // read store at walk slot
		logic rd_emit;  // move read data to response register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic last_elem; // walk is on the back element
		logic rsp_free;  // response register can load this cycle
	} dp_sts_t;

endpackage
`default_nettype wire

FILE: src/double_ended_list_store_unit.sv
// Top level of the double-ended list store: controller plus datapath.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries an operation and a
//   signed 32-bit value: push front, push back, drop front, read all.
//   Response channel (rsp_valid / rsp_stall / rsp) returns item, status, last.
//   Push and drop give one response (item zero, last set); status says ok,
//   empty (drop or read on an empty list) or full (push refused, list kept).
//   Read all gives one response per stored element from front to back, last
//   set on the back element; the list is left as it was.
// Sequencing:
//   Push, drop and an empty read answer in the cycle after acceptance. A
//   read-all walk handles each element in turn: S_RD_ADDR addresses the
//   single-port ring store, S_RD_DATA moves its registered read data into
//   the response register. Requests are stalled during the walk.
// Stall:
//   The response register holds while rsp_stall is high; a new request is
//   accepted only when the response register is empty or being taken.
// Reset:
//   arst_n clears the list (front slot and count to zero) and the response
//   valid. Store contents are not cleared; only written slots are ever read.
`default_nettype none
module double_ended_list_store_unit #(
	parameter int DEPTH = dels_pkg::DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire dels_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output dels_pkg::rsp_t      rsp
);
	import dels_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing: accept, then optional read walk
	dels_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.operation (req.operation),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	// ring store, pointers and response register
	dels_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

FILE: src/dels_ctrl.sv
// Controller state machine of the double-ended list store.
`default_nettype none
module dels_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic [1:0]        operation,
	input  wire dels_pkg::dp_sts_t sts,
	output logic                   req_stall,
	output dels_pkg::dp_cmd_t      cmd
);
	import dels_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE    = 3'b001,
		S_RD_ADDR = 3'b010,
		S_RD_DATA = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		req_stall    = 1'b1;
		cmd.accept   = 1'b0;
		cmd.rd_issue = 1'b0;
		cmd.rd_emit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_stall  = !sts.rsp_free;
				cmd.accept = req_valid && sts.rsp_free;
				if (cmd.accept && operation == OP_READ_ALL && !sts.empty) begin
					state_d = S_RD_ADDR;
				end
			end
			S_RD_ADDR: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_RD_DATA;
			end
			S_RD_DATA: begin
				if (sts.rsp_free) begin
					cmd.rd_emit = 1'b1;
					state_d     = sts.last_elem ? S_IDLE : S_RD_ADDR;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: src/dels_dp.sv
// Datapath of the double-ended list store: ring store, pointers, response register.
`default_nettype none
module dels_dp #(
	parameter int DEPTH = dels_pkg::DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dels_pkg::req_t    req,
	input  wire dels_pkg::dp_cmd_t cmd,
	input  wire logic              rsp_stall,
	output dels_pkg::dp_sts_t      sts,
	output logic                   rsp_valid,
	output dels_pkg::rsp_t         rsp
);
	import dels_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic signed [31:0] mem [DEPTH];

	logic [AW-1:0]      front_q, rd_slot_q;
	logic [CW-1:0]      count_q, remain_q;
	logic signed [31:0] rdata_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [AW-1:0] front_prev, front_next, rd_next, back_slot;
	logic [SW-1:0] back_sum;
	logic          empty, full;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          load_rsp;
	rsp_t          rsp_d;

	function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] s);
		return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
	endfunction

	function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] s);
		return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
	endfunction

	assign empty      = (count_q == '0);
	assign full       = (count_q == CW'(DEPTH));
	assign front_prev = slot_prev(front_q);
	assign front_next = slot_next(front_q);
	assign rd_next    = slot_next(rd_slot_q);

	// back slot = front + count, wrapped once (count < DEPTH when used)
	always_comb begin
		back_sum = SW'(front_q) + SW'(count_q);
		if (back_sum >= SW'(DEPTH)) begin
			back_sum = back_sum - SW'(DEPTH);
		end
		back_slot = back_sum[AW-1:0];
	end

	assign sts.empty     = empty;
	assign sts.last_elem = (remain_q == CW'(1));
	assign sts.rsp_free  = !rsp_valid_q || !rsp_stall;

	// request decode
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = back_slot;
		load_rsp = 1'b0;
		rsp_d    = '{item: '0, status: ST_OK, last: 1'b1};
		if (cmd.accept) begin
			unique case (req.operation) inside
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					load_rsp = 1'b1;
					if (full) begin
						rsp_d.status = ST_FULL;
					end else begin
						wr_en   = 1'b1;
						wr_addr = (req.operation == OP_PUSH_FRONT) ? front_prev : back_slot;
					end
				end
				default: begin
					load_rsp = (req.operation == OP_DROP_FRONT) || empty;
					if (empty) begin
						rsp_d.status = ST_EMPTY;
					end
				end
			endcase
		end else if (cmd.rd_emit) begin
			load_rsp   = 1'b1;
			rsp_d.item = rdata_q;
			rsp_d.last = sts.last_elem;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= req.value;
		end
		if (cmd.rd_issue) begin
			rdata_q <= mem[rd_slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			rd_slot_q   <= '0;
			remain_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				case (req.operation)
					OP_PUSH_FRONT: begin
						if (!full) begin
							front_q <= front_prev;
							count_q <= count_q + CW'(1);
						end
					end
					OP_PUSH_BACK: begin
						if (!full) begin
							count_q <= count_q + CW'(1);
						end
					end
					OP_DROP_FRONT: begin
						if (!empty) begin
							front_q <= front_next;
							count_q <= count_q - CW'(1);
						end
					end
					default: begin
						rd_slot_q <= front_q;
						remain_q  <= count_q;
					end
				endcase
			end
			if (cmd.rd_emit) begin
				rd_slot_q <= rd_next;
				remain_q  <= remain_q - CW'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

FILE: src/dels_chk.sv
// Port-level checker of the double-ended list store and its bind.
`default_nettype none
module dels_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire dels_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire dels_pkg::rsp_t rsp
);
	import dels_pkg::*;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// error responses carry no item and end the request
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.item == '0 && rsp.last)
		else $error("error response malformed");

	// mid-walk responses keep requests out
	a_walk_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> req_stall)
		else $error("request accepted during read walk");

	// push and drop answer next cycle with a single final response
	a_single_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.operation != OP_READ_ALL
		|=> rsp_valid && rsp.last && rsp.item == '0)
		else $error("push or drop response missing");

endmodule

bind double_ended_list_store_unit dels_chk u_dels_chk (.*);
`default_nettype wire

FILE: tb/double_ended_list_store_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the double-ended list store unit.
module double_ended_list_store_unit_test;
	import dels_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int ITEM_TARGET = 180;   // requests to generate, directed part included
	localparam int HOLD_CYCLES = 80;    // long receiver hold-off, fills the unit
	localparam int IDLE_LIMIT  = 2000;  // watchdog: cycles with no handshake at all
	localparam int TAIL_CYCLES = 20;    // quiet time after the last response

	// One queued request plus how the sender treats it.
	typedef struct {
		req_t op_req;
		int   gap;        // idle cycles before it is offered
		bit   wait_drain; // offer only once every response has come back
	} pending_req_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	double_ended_list_store_unit #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Shadow copy of the list: ring contents, front slot and element count.
	logic signed [31:0] list_ring [DEPTH];
	int                 list_front = 0;
	int                 list_count = 0;
	rsp_t               expected_rsps [$];

	pending_req_t pending_reqs [$];
	pending_req_t cur_req;
	bit           have_item = 1'b0;
	int           gap_left = 0;

	// Handshake counters. The monitor bumps the accepted counts at the rising
	// edge; the driver and receiver read them at the falling edge.
	int accepted_reqs = 0;
	int offered_reqs  = 0;
	int taken_rsps    = 0;
	int seen_rsps     = 0;

	int rsp_wait  = 3;
	int hold_left = 0;
	int idle_cycles = 0;

	// Stimulus bookkeeping: list length as the generator sees it.
	int gen_count = 0;
	int made_reqs = 0;

	int errors        = 0;
	int full_replies  = 0;
	int empty_replies = 0;
	int longest_read  = 0;
	int hold_offs     = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// Applies one accepted request to the shadow list and queues the
	// responses it must produce.
	function automatic void predict_list_op(input req_t r);
		rsp_t res;
		int   slot;
		res = '0;
		res.last = 1'b1;
		res.status = ST_OK;
		case (r.operation)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (list_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					if (r.operation == OP_PUSH_FRONT) begin
						list_front = (list_front + DEPTH - 1) % DEPTH;
						slot = list_front;
					end else begin
						slot = (list_front + list_count) % DEPTH;
					end
					list_ring[slot] = r.value;
					list_count++;
				end
				expected_rsps.push_back(res);
			end
			OP_DROP_FRONT: begin
				if (list_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					list_front = (list_front + 1) % DEPTH;
					list_count--;
				end
				expected_rsps.push_back(res);
			end
			default: begin
				// read all: one response per element, front to back, list untouched
				if (list_count == 0) begin
					res.status = ST_EMPTY;
					expected_rsps.push_back(res);
				end else begin
					if (list_count > longest_read)
						longest_read = list_count;
					for (int i = 0; i < list_count; i++) begin
						res.item = list_ring[(list_front + i) % DEPTH];
						res.last = (i == list_count - 1);
						expected_rsps.push_back(res);
					end
				end
			end
		endcase
	endfunction

	// Mostly random values, with the signed extremes and the all-zero and
	// all-one patterns mixed in.
	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 15))
			0: begin
				return 32'sh7fffffff;
			end
			1: begin
				return 32'sh80000000;
			end
			2: begin
				return 32'sh0;
			end
			3: begin
				return -32'sd1;
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	function automatic logic [1:0] push_op();
		return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
	endfunction

	// Queues one request. Gaps are random 0..9 except in every third block of
	// 25 requests, which goes back to back. Two requests make the sender wait
	// until the unit has answered everything before them.
	task automatic add_req(input logic [1:0] op, input logic signed [31:0] val);
		pending_req_t p;
		p.op_req.operation = op;
		p.op_req.value = val;
		p.gap = ((made_reqs / 25) % 3 == 1) ? 0 : $urandom_range(0, 9);
		p.wait_drain = (made_reqs == 60 || made_reqs == 130);
		pending_reqs.push_back(p);
		made_reqs++;
		if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && gen_count < DEPTH)
			gen_count++;
		else if (op == OP_DROP_FRONT && gen_count > 0)
			gen_count--;
	endtask

	// Driver: a request stays on the bus until taken; the next one, if any,
	// follows after its own gap. A single assignment to req_valid per edge.
	always @(negedge clk) begin
		if (arst_n && !(req_valid && accepted_reqs != offered_reqs)) begin
			if (!have_item && pending_reqs.size() != 0) begin
				cur_req = pending_reqs.pop_front();
				have_item = 1'b1;
				gap_left = cur_req.gap;
			end
			if (have_item && gap_left == 0 &&
					(!cur_req.wait_drain || expected_rsps.size() == 0)) begin
				req_valid <= 1'b1;
				req <= cur_req.op_req;
				offered_reqs++;
				have_item = 1'b0;
			end else begin
				req_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end
		end
	end

	// Receiver: random stall per response, a no-stall stretch in every third
	// block of 50 responses, and two long hold-offs counted here so that the
	// unit fills and stalls its request side while the driver keeps offering.
	always @(negedge clk) begin
		if (arst_n) begin
			if (taken_rsps != seen_rsps) begin
				seen_rsps = taken_rsps;
				rsp_wait = ((seen_rsps / 50) % 3 == 2) ? 0 : $urandom_range(0, 9);
				if (seen_rsps == 30 || seen_rsps == 200) begin
					hold_left = HOLD_CYCLES;
					hold_offs++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (rsp_valid && rsp_wait > 0) begin
				rsp_wait--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Monitor: predicts on every accepted request, checks every accepted
	// response against the oldest expectation, field by field.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predict_list_op(req);
				accepted_reqs++;
			end
			if (rsp_valid && !rsp_stall) begin
				taken_rsps++;
				if (expected_rsps.size() == 0) begin
					report_mismatch($sformatf("response %0d arrived with none expected",
						taken_rsps));
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.item !== want.item)
						report_mismatch($sformatf("response %0d item %0d, want %0d",
							taken_rsps, rsp.item, want.item));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("response %0d status %0d, want %0d",
							taken_rsps, rsp.status, want.status));
					if (rsp.last !== want.last)
						report_mismatch($sformatf("response %0d last %0b, want %0b",
							taken_rsps, rsp.last, want.last));
					if (want.status == ST_FULL)
						full_replies++;
					if (want.status == ST_EMPTY)
						empty_replies++;
				end
			end
		end
	end

	// Watchdog: too long without any handshake means the unit hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		int n;
		int pick;
		bit first_seq;
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;

		// Directed: empty read and drop, extremes at both ends, ordering
		// check by read-all, then drops down past empty.
		add_req(OP_READ_ALL, rand_value());
		add_req(OP_DROP_FRONT, rand_value());
		add_req(OP_PUSH_BACK, 32'sh7fffffff);
		add_req(OP_PUSH_FRONT, 32'sh80000000);
		add_req(OP_PUSH_BACK, -32'sd1);
		add_req(OP_PUSH_FRONT, 32'sh0);
		add_req(OP_READ_ALL, rand_value());
		add_req(OP_DROP_FRONT, rand_value());
		add_req(OP_READ_ALL, rand_value());
		for (int i = 0; i < 3; i++)
			add_req(OP_DROP_FRONT, rand_value());
		add_req(OP_DROP_FRONT, rand_value());
		add_req(OP_READ_ALL, rand_value());

		// Random part built from well-formed sequences: fill to full and push
		// past it, drain to empty and drop past it, or a random mix. The
		// first sequence is always a fill so the full case comes early.
		first_seq = 1'b1;
		while (made_reqs < ITEM_TARGET) begin
			kind = first_seq ? 0 : $urandom_range(0, 5);
			first_seq = 1'b0;
			if (kind == 0) begin
				while (gen_count < DEPTH)
					add_req(push_op(), rand_value());
				n = $urandom_range(1, 2);
				for (int i = 0; i < n; i++)
					add_req(push_op(), rand_value());
				add_req(OP_READ_ALL, rand_value());
			end else if (kind == 1) begin
				while (gen_count > 0)
					add_req(OP_DROP_FRONT, rand_value());
				add_req(OP_DROP_FRONT, rand_value());
				add_req(OP_READ_ALL, rand_value());
			end else begin
				n = $urandom_range(4, 12);
				for (int i = 0; i < n; i++) begin
					pick = $urandom_range(0, 9);
					if (pick < 5)
						add_req(push_op(), rand_value());
					else if (pick < 8)
						add_req(OP_DROP_FRONT, rand_value());
					else
						add_req(OP_READ_ALL, rand_value());
				end
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all requests taken, then all responses back, then a quiet tail
		while (pending_reqs.size() != 0 || have_item || accepted_reqs != offered_reqs)
			@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d requests, %0d responses, %0d refused pushes, %0d empty replies",
			accepted_reqs, taken_rsps, full_replies, empty_replies);
		$display("run: longest read-out %0d elements, %0d long receiver hold-offs",
			longest_read, hold_offs);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/dels_pkg.sv
src/dels_ctrl.sv
src/dels_dp.sv
src/double_ended_list_store_unit.sv
src/dels_chk.sv
tb/double_ended_list_store_unit_test.sv
